>>> design/ppg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ppg_pkg;

   localparam int COORD_W    = 11;
   localparam int SIZE_W     = 6;
   localparam int RESULT_CAP = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [COORD_W-1:0] NEAR_RESET = 11'd25;

   typedef enum logic {
      OP_ADD    = 1'b0,
      OP_FINISH = 1'b1
   } op_type;

   typedef enum logic {
      REG_NEAR_DISTANCE = 1'b0,
      REG_UNUSED        = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic load_point;
      logic scan_start;
      logic scan_step;
      logic cnt_read;
      logic commit;
      logic mark_overflow;
      logic emit_start;
      logic emit_read;
      logic emit_load;
      logic clear;
   } cmd_type;

   typedef struct packed {
      logic store_full;
      logic store_empty;
      logic scan_last;
      logic no_groups;
      logic emit_last;
      logic out_free;
   } status_type;

endpackage
`default_nettype wire

>>> design/ppg_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface ppg_req_if;
   import ppg_pkg::*;

   logic               valid;
   logic               ready;
   logic               op;
   logic [COORD_W-1:0] x_coord;
   logic [COORD_W-1:0] y_coord;

   modport source (output valid, output op, output x_coord, output y_coord, input ready);
   modport sink   (input valid, input op, input x_coord, input y_coord, output ready);
endinterface
`default_nettype wire

>>> design/ppg_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface ppg_rsp_if;
   import ppg_pkg::*;

   logic              valid;
   logic              ready;
   logic [SIZE_W-1:0] group_size;
   logic              last_group;
   logic              points_dropped;

   modport source (output valid, output group_size, output last_group,
                   output points_dropped, input ready);
   modport sink   (input valid, input group_size, input last_group,
                   input points_dropped, output ready);
endinterface
`default_nettype wire

>>> design/proximity_point_grouper.sv
`timescale 1ns / 1ps
`default_nettype none
// Add beat: one store read per cycle in the proximity scan, then a count read and commit;
//   no scan with an empty store; a dropped point (store full) only sets the drop flag.
// Finish beat: one count-memory read per result, results issued while the sink takes them;
//   an empty finish emits nothing and only clears the counts.
// Reset: synchronous, active high; clears point and group counts, drop flag and the output
//   valid flag, and loads near_distance with 25. Point and count memories are not cleared.
module proximity_point_grouper #(
   parameter int MAX_POINTS = 32
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   ppg_req_if.sink                                 req_chan,
   ppg_rsp_if.source                               rsp_chan,
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [ppg_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire logic [ppg_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic      [ppg_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                    csr_pready
);
   import ppg_pkg::*;

   logic [COORD_W-1:0] near_ff;
   reg_index_type      reg_sel;
   logic               csr_wr;
   cmd_type            cmd;
   status_type         status;

   assign reg_sel    = reg_index_type'(csr_paddr[CSR_ADDR_W-1]);
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         near_ff <= NEAR_RESET;
      end else if (csr_wr && (reg_sel == REG_NEAR_DISTANCE)) begin
         near_ff <= csr_pwdata[COORD_W-1:0];
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_NEAR_DISTANCE: csr_prdata = CSR_DATA_W'(near_ff);
         default:           csr_prdata = '0;
      endcase
   end

   ppg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_op    (req_chan.op),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   ppg_datapath #(.MAX_POINTS(MAX_POINTS)) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .near_distance      (near_ff),
      .x_coord            (req_chan.x_coord),
      .y_coord            (req_chan.y_coord),
      .rsp_ready          (rsp_chan.ready),
      .rsp_valid          (rsp_chan.valid),
      .rsp_group_size     (rsp_chan.group_size),
      .rsp_last_group     (rsp_chan.last_group),
      .rsp_points_dropped (rsp_chan.points_dropped)
   );
endmodule
`default_nettype wire

>>> design/ppg_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module ppg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data_ff
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end
endmodule
`default_nettype wire

>>> design/ppg_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module ppg_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   input  wire logic                req_op,
   output logic                     req_ready,
   input  wire ppg_pkg::status_type status,
   output ppg_pkg::cmd_type         cmd
);
   import ppg_pkg::*;

   typedef enum logic [2:0] {
      IDLE,
      SCAN,
      SCAN_TAIL,
      CNT_RD,
      COMMIT,
      EMIT_RD,
      EMIT_LOAD
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign req_ready = (state_ff == IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         IDLE: begin
            if (accept) begin
               if (op_type'(req_op) == OP_ADD) begin
                  if (status.store_full) begin
                     cmd.mark_overflow = 1'b1;
                  end else begin
                     cmd.load_point = 1'b1;
                     cmd.scan_start = 1'b1;
                     state_in = status.store_empty ? CNT_RD : SCAN;
                  end
               end else begin
                  if (status.no_groups) begin
                     cmd.clear = 1'b1;
                  end else begin
                     cmd.emit_start = 1'b1;
                     state_in = EMIT_RD;
                  end
               end
            end
         end
         SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_last) begin
               state_in = SCAN_TAIL;
            end
         end
         SCAN_TAIL: begin
            state_in = CNT_RD;
         end
         CNT_RD: begin
            cmd.cnt_read = 1'b1;
            state_in = COMMIT;
         end
         COMMIT: begin
            cmd.commit = 1'b1;
            state_in = IDLE;
         end
         EMIT_RD: begin
            cmd.emit_read = 1'b1;
            state_in = EMIT_LOAD;
         end
         EMIT_LOAD: begin
            if (status.out_free) begin
               cmd.emit_load = 1'b1;
               if (status.emit_last) begin
                  cmd.clear = 1'b1;
                  state_in = IDLE;
               end else begin
                  state_in = EMIT_RD;
               end
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule
`default_nettype wire

>>> design/ppg_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module ppg_datapath #(
   parameter int MAX_POINTS = 32
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire ppg_pkg::cmd_type              cmd,
   output ppg_pkg::status_type                status,
   input  wire logic [ppg_pkg::COORD_W-1:0]   near_distance,
   input  wire logic [ppg_pkg::COORD_W-1:0]   x_coord,
   input  wire logic [ppg_pkg::COORD_W-1:0]   y_coord,
   input  wire logic                          rsp_ready,
   output logic                               rsp_valid,
   output logic      [ppg_pkg::SIZE_W-1:0]    rsp_group_size,
   output logic                               rsp_last_group,
   output logic                               rsp_points_dropped
);
   import ppg_pkg::*;

   localparam int IDX_W = $clog2(MAX_POINTS);
   localparam int CNT_W = $clog2(MAX_POINTS + 1);
   localparam int ENT_W = 2 * COORD_W + IDX_W;

   logic [COORD_W-1:0] x_ff, y_ff;
   logic [IDX_W-1:0]   scan_idx_ff, scan_idx_in;
   logic               cmp_valid_ff;
   logic               found_ff, found_in;
   logic [IDX_W-1:0]   grp_ff, grp_in;
   logic [CNT_W-1:0]   point_total_ff, point_total_in;
   logic [CNT_W-1:0]   group_total_ff, group_total_in;
   logic               overflow_ff, overflow_in;
   logic [IDX_W-1:0]   emit_idx_ff, emit_idx_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [SIZE_W-1:0]  size_ff;
   logic               last_ff, drop_ff;

   logic [ENT_W-1:0]   ent_rd;
   logic [COORD_W-1:0] ent_x, ent_y, dx, dy;
   logic [IDX_W-1:0]   ent_grp, sel_grp, cnt_raddr;
   logic [CNT_W-1:0]   cnt_rd;
   logic [CNT_W-1:0]   cnt_wdata;
   logic               hit;
   logic [7:0]         emit_next;

   ppg_ram #(.WIDTH(ENT_W), .DEPTH(MAX_POINTS)) u_store (
      .clock      (clock),
      .wr_en      (cmd.commit),
      .wr_addr    (point_total_ff[IDX_W-1:0]),
      .wr_data    ({x_ff, y_ff, sel_grp}),
      .rd_en      (cmd.scan_step),
      .rd_addr    (scan_idx_ff),
      .rd_data_ff (ent_rd)
   );

   assign sel_grp   = found_ff ? grp_ff : group_total_ff[IDX_W-1:0];
   assign cnt_raddr = cmd.emit_read ? emit_idx_ff : sel_grp;
   assign cnt_wdata = found_ff ? (cnt_rd + CNT_W'(1)) : CNT_W'(1);

   ppg_ram #(.WIDTH(CNT_W), .DEPTH(MAX_POINTS)) u_counts (
      .clock      (clock),
      .wr_en      (cmd.commit),
      .wr_addr    (sel_grp),
      .wr_data    (cnt_wdata),
      .rd_en      (cmd.cnt_read || cmd.emit_read),
      .rd_addr    (cnt_raddr),
      .rd_data_ff (cnt_rd)
   );

   assign ent_x   = ent_rd[ENT_W-1 -: COORD_W];
   assign ent_y   = ent_rd[IDX_W +: COORD_W];
   assign ent_grp = ent_rd[IDX_W-1:0];
   assign dx      = (x_ff > ent_x) ? (x_ff - ent_x) : (ent_x - x_ff);
   assign dy      = (y_ff > ent_y) ? (y_ff - ent_y) : (ent_y - y_ff);
   assign hit     = cmp_valid_ff && (dx < near_distance) && (dy < near_distance);

   assign emit_next = 8'(emit_idx_ff) + 8'd1;

   assign status.store_full  = (point_total_ff == CNT_W'(MAX_POINTS));
   assign status.store_empty = (point_total_ff == '0);
   assign status.scan_last   = ((CNT_W'(scan_idx_ff) + CNT_W'(1)) == point_total_ff);
   assign status.no_groups   = (group_total_ff == '0);
   assign status.emit_last   = (emit_next == 8'(group_total_ff)) ||
                               (emit_next == 8'(RESULT_CAP));
   assign status.out_free    = !rsp_valid_ff || rsp_ready;

   always_comb begin
      scan_idx_in = scan_idx_ff;
      found_in    = found_ff;
      grp_in      = grp_ff;
      if (cmd.scan_start) begin
         scan_idx_in = '0;
         found_in    = 1'b0;
      end else begin
         if (cmd.scan_step) begin
            scan_idx_in = scan_idx_ff + IDX_W'(1);
         end
         if (hit) begin
            found_in = 1'b1;
            grp_in   = ent_grp;
         end
      end
   end

   always_comb begin
      point_total_in = point_total_ff;
      group_total_in = group_total_ff;
      overflow_in    = overflow_ff;
      priority if (cmd.clear) begin
         point_total_in = '0;
         group_total_in = '0;
         overflow_in    = 1'b0;
      end else if (cmd.commit) begin
         point_total_in = point_total_ff + CNT_W'(1);
         group_total_in = group_total_ff + CNT_W'(!found_ff);
      end else if (cmd.mark_overflow) begin
         overflow_in = 1'b1;
      end
   end

   always_comb begin
      emit_idx_in = emit_idx_ff;
      if (cmd.emit_start) begin
         emit_idx_in = '0;
      end else if (cmd.emit_load) begin
         emit_idx_in = emit_idx_ff + IDX_W'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmp_valid_ff   <= 1'b0;
         found_ff       <= 1'b0;
         scan_idx_ff    <= '0;
         point_total_ff <= '0;
         group_total_ff <= '0;
         overflow_ff    <= 1'b0;
         emit_idx_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         cmp_valid_ff   <= cmd.scan_step;
         found_ff       <= found_in;
         scan_idx_ff    <= scan_idx_in;
         point_total_ff <= point_total_in;
         group_total_ff <= group_total_in;
         overflow_ff    <= overflow_in;
         emit_idx_ff    <= emit_idx_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      grp_ff <= grp_in;
      if (cmd.load_point) begin
         x_ff <= x_coord;
         y_ff <= y_coord;
      end
      if (cmd.emit_load) begin
         size_ff <= SIZE_W'(cnt_rd);
         last_ff <= status.emit_last;
         drop_ff <= overflow_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_group_size     = size_ff;
   assign rsp_last_group     = last_ff;
   assign rsp_points_dropped = drop_ff;
endmodule
`default_nettype wire

>>> design/ppg_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module ppg_checker (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         req_valid,
   input wire logic                         req_ready,
   input wire logic                         req_op,
   input wire logic                         rsp_valid,
   input wire logic                         rsp_ready,
   input wire logic [ppg_pkg::SIZE_W-1:0]   rsp_group_size,
   input wire logic                         rsp_last_group,
   input wire logic                         rsp_points_dropped
);
   import ppg_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat withdrawn while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         $stable(rsp_group_size) && $stable(rsp_last_group) && $stable(rsp_points_dropped))
      else $error("stalled result payload changed");

   a_busy_in_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_group |-> !req_ready)
      else $error("input taken in the middle of a finish run");

   a_add_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (op_type'(req_op) == OP_ADD) && !rsp_valid |=> !rsp_valid)
      else $error("add beat produced a result");
endmodule

bind proximity_point_grouper ppg_checker u_ppg_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_chan.valid),
   .req_ready          (req_chan.ready),
   .req_op             (req_chan.op),
   .rsp_valid          (rsp_chan.valid),
   .rsp_ready          (rsp_chan.ready),
   .rsp_group_size     (rsp_chan.group_size),
   .rsp_last_group     (rsp_chan.last_group),
   .rsp_points_dropped (rsp_chan.points_dropped)
);
`default_nettype wire

>>> bench/proximity_point_grouper_test.sv
`timescale 1ns / 1ps
module proximity_point_grouper_test;
   import ppg_pkg::*;

   localparam int MAX_POINTS = 32;
   localparam int SETTLE_CYCLES = 40;

   typedef struct packed {
      op_type             op;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
   } point_beat_type;

   typedef struct packed {
      logic [SIZE_W-1:0] count;
      logic              last;
      logic              dropped;
   } group_result_type;

   logic clock;
   logic reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   ppg_req_if req_bus ();
   ppg_rsp_if rsp_bus ();

   proximity_point_grouper #(.MAX_POINTS(MAX_POINTS)) DUT (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   point_beat_type   point_feed[$];
   group_result_type pending_sizes[$];
   int               sender_idle_pct;
   int               receiver_idle_pct;
   int               error_count;
   int               queued_beats;

   logic [COORD_W-1:0] near_limit;
   logic [COORD_W-1:0] pt_x [MAX_POINTS];
   logic [COORD_W-1:0] pt_y [MAX_POINTS];
   int                 pt_group [MAX_POINTS];
   int                 group_fill [MAX_POINTS];
   int                 stored_count;
   int                 group_count;
   logic               overflow_flag;

   function automatic void track_groups(input point_beat_type beat);
      int               i;
      int               grp;
      int               dx;
      int               dy;
      bit               hit;
      group_result_type res;
      if (beat.op == OP_ADD) begin
         if (stored_count >= MAX_POINTS) begin
            overflow_flag = 1'b1;
            return;
         end
         hit = 1'b0;
         grp = 0;
         for (i = 0; i < stored_count; i++) begin
            dx = (beat.x > pt_x[i]) ? int'(beat.x - pt_x[i]) : int'(pt_x[i] - beat.x);
            dy = (beat.y > pt_y[i]) ? int'(beat.y - pt_y[i]) : int'(pt_y[i] - beat.y);
            if (dx < int'(near_limit) && dy < int'(near_limit)) begin
               grp = pt_group[i];
               hit = 1'b1;
            end
         end
         if (!hit) begin
            grp = group_count;
            group_fill[grp] = 0;
            group_count++;
         end
         pt_x[stored_count] = beat.x;
         pt_y[stored_count] = beat.y;
         pt_group[stored_count] = grp;
         group_fill[grp]++;
         stored_count++;
      end else begin
         for (i = 0; i < group_count && i < RESULT_CAP; i++) begin
            res.count = SIZE_W'(group_fill[i]);
            res.last = (i == group_count - 1 || i == RESULT_CAP - 1);
            res.dropped = overflow_flag;
            pending_sizes = {pending_sizes, res};
         end
         stored_count = 0;
         group_count = 0;
         overflow_flag = 1'b0;
      end
   endfunction

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #10ms;
      $display("proximity_point_grouper test failed");
      $finish;
   end

   // driver: advance to the next beat once the current one is taken
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (point_feed.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
            req_bus.valid <= 1'b1;
            req_bus.op <= point_feed[0].op;
            req_bus.x_coord <= point_feed[0].x;
            req_bus.y_coord <= point_feed[0].y;
            void'(point_feed.pop_front());
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // monitor: predict on each request beat, check each result beat
   always @(posedge clock) begin
      group_result_type got;
      group_result_type want;
      point_beat_type   seen;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            seen.op = op_type'(req_bus.op);
            seen.x = req_bus.x_coord;
            seen.y = req_bus.y_coord;
            track_groups(seen);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.count = rsp_bus.group_size;
            got.last = rsp_bus.last_group;
            got.dropped = rsp_bus.points_dropped;
            if (pending_sizes.size() == 0) begin
               $display("%0t: unexpected result size=%0d last=%0b dropped=%0b",
                        $time, got.count, got.last, got.dropped);
               error_count++;
            end else begin
               want = pending_sizes.pop_front();
               if (got !== want) begin
                  $display("%0t: mismatch expected size=%0d last=%0b dropped=%0b, %s%0d %0b %0b",
                           $time, want.count, want.last, want.dropped,
                           "actual size/last/dropped=", got.count, got.last, got.dropped);
                  error_count++;
               end
            end
         end
      end
      rsp_bus.ready <= !reset && ($urandom_range(99) >= receiver_idle_pct);
   end

   task automatic write_near(input logic [COORD_W-1:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_ADDR_W'(4 * int'(REG_NEAR_DISTANCE));
      csr_pwdata <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      near_limit = value;
   endtask

   task automatic wait_drained();
      do @(posedge clock);
      while (point_feed.size() != 0 || req_bus.valid || pending_sizes.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic push_beat(input op_type op, input int x, input int y);
      point_beat_type beat;
      beat.op = op;
      beat.x = COORD_W'(x);
      beat.y = COORD_W'(y);
      point_feed = {point_feed, beat};
      queued_beats++;
   endtask

   // queue one scene of clustered points with noise, then a finish beat
   task automatic queue_scene(input int n_pts);
      int cx [4];
      int cy [4];
      int n_clusters;
      int k;
      int pick;
      int span;
      int x;
      int y;
      n_clusters = $urandom_range(1, 4);
      span = int'(near_limit);
      for (k = 0; k < 4; k++) begin
         cx[k] = $urandom_range(0, 2047);
         cy[k] = $urandom_range(0, 2047);
      end
      for (k = 0; k < n_pts; k++) begin
         pick = $urandom_range(99);
         if (pick < 78) begin
            x = cx[k % n_clusters] + $urandom_range(0, 2 * span) - span;
            y = cy[k % n_clusters] + $urandom_range(0, 2 * span) - span;
            x = (x < 0) ? 0 : (x > 2047) ? 2047 : x;
            y = (y < 0) ? 0 : (y > 2047) ? 2047 : y;
         end else if (pick < 94) begin
            x = $urandom_range(0, 2047);
            y = $urandom_range(0, 2047);
         end else begin
            x = $urandom_range(1) * 2047;
            y = $urandom_range(1) * 2047;
         end
         push_beat(OP_ADD, x, y);
      end
      push_beat(OP_FINISH, $urandom_range(0, 2047), $urandom_range(0, 2047));
   endtask

   initial begin
      int phase;
      int setting;
      int pick;
      int target;
      reset = 1'b1;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      req_bus.valid = 1'b0;
      req_bus.op = OP_ADD;
      req_bus.x_coord = '0;
      req_bus.y_coord = '0;
      rsp_bus.ready = 1'b0;
      error_count = 0;
      queued_beats = 0;
      near_limit = NEAR_RESET;
      stored_count = 0;
      group_count = 0;
      overflow_flag = 1'b0;
      sender_idle_pct = 33;
      receiver_idle_pct = 82;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      push_beat(OP_FINISH, 0, 0);
      push_beat(OP_ADD, 0, 0);
      push_beat(OP_ADD, 2047, 2047);
      push_beat(OP_ADD, 0, 2047);
      push_beat(OP_ADD, 2047, 0);
      push_beat(OP_ADD, 24, 24);
      push_beat(OP_ADD, 25, 0);
      push_beat(OP_ADD, 1000, 1000);
      push_beat(OP_ADD, 1040, 1000);
      push_beat(OP_ADD, 1020, 1000);
      push_beat(OP_ADD, 2022, 2023);
      push_beat(OP_FINISH, 2047, 2047);
      push_beat(OP_FINISH, 1365, 682);
      push_beat(OP_ADD, 682, 1365);
      push_beat(OP_FINISH, 0, 0);
      wait_drained();

      for (phase = 0; phase < 3; phase++) begin
         sender_idle_pct = (phase == 0) ? 33 : (phase == 1) ? 82 : 0;
         receiver_idle_pct = (phase == 0) ? 82 : (phase == 1) ? 33 : 0;
         for (setting = 0; setting < 4; setting++) begin
            case (setting)
               0: write_near(11'd1);
               1: write_near(11'd2047);
               2: write_near(COORD_W'($urandom_range(2, 120)));
               default: write_near(COORD_W'($urandom_range(1, 2047)));
            endcase
            target = queued_beats + 22;
            if (setting == 2)
               queue_scene($urandom_range(33, 38));
            while (queued_beats < target) begin
               pick = $urandom_range(99);
               if (pick < 8)
                  queue_scene(0);
               else if (pick < 18)
                  queue_scene($urandom_range(20, 34));
               else
                  queue_scene($urandom_range(1, 10));
               if ($urandom_range(99) < 15)
                  wait_drained();
            end
            wait_drained();
         end
      end

      if (error_count == 0)
         $display("proximity_point_grouper test passed");
      else
         $display("proximity_point_grouper test failed");
      $finish;
   end

endmodule

>>> sim.f
design/ppg_pkg.sv
design/ppg_req_if.sv
design/ppg_rsp_if.sv
design/ppg_ram.sv
design/ppg_ctrl.sv
design/ppg_datapath.sv
design/proximity_point_grouper.sv
design/ppg_checker.sv
bench/proximity_point_grouper_test.sv
